// ----- hw/rtl/meea_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package meea_pkg;
	localparam int W = 64;
	localparam int CNT_W = $clog2(W);

	typedef struct packed {
		logic [W-2:0] modulus;
		logic [W-2:0] value;
	} in_t;

	typedef struct packed {
		logic [W-2:0]        divisor_common;
		logic signed [W-1:0] coeff_modulus;
		logic signed [W-1:0] coeff_value;
		logic [W-2:0]        inverse;
		logic                inverse_exists;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_MUL_S,
		ST_MUL_T,
		ST_RED,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

// ----- hw/rtl/meea_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle
module meea_div import meea_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quotient,
	output logic [W-1:0]      remainder
);
	logic [W-1:0]     quo_q, rem_q, dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q, done_q;
	logic [W:0]       shifted, diff;

	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		diff    = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(W-1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

// ----- hw/rtl/meea_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// shift-add multiplier, low W bits of the product
module meea_mul import meea_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] op_a,
	input  wire logic [W-1:0] op_b,
	output logic              done,
	output logic [W-1:0]      product
);
	logic [W-1:0]     a_q, b_q, acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(W-1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= op_a;
			b_q   <= op_b;
			acc_q <= '0;
		end else if (run_q) begin
			if (b_q[0])
				acc_q <= acc_q + a_q;
			a_q <= {a_q[W-2:0], 1'b0};
			b_q <= {1'b0, b_q[W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;
endmodule
`default_nettype wire

// ----- hw/rtl/modular_inverse_ext_euclid.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Each Euclid step is a check, then one divide and two multiplies on the bit-serial
//   units; when an inverse exists, it is then reduced on the divider before done strobes.
// Throughput: one transfer at a time; busy drops in the cycle of the result strobe.
// Result is shown for one cycle on done; the receiver cannot stall.
// Reset (arst_n low, async): sequencer idle, coefficient registers at 1/0/0/1.
module modular_inverse_ext_euclid import meea_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire in_t  operands,
	output logic      busy,
	output logic      done,
	output out_t      result
);
	state_t state_q, state_d;

	// Euclid registers
	logic [W-2:0] n_q;
	logic [W-1:0] dvd_q, dvs_q, quo_q;
	logic [W-1:0] sp_q, sc_q, tp_q, tc_q;
	logic         done_q;
	out_t         res_q;

	// shared units
	logic         div_start, div_done, mul_start, mul_done;
	logic [W-1:0] div_a, div_b, div_quo, div_rem, mul_a, mul_b, mul_p;
	logic         exists;

	assign exists = (dvd_q == W'(1)) && (n_q != '0);

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		mul_start = 1'b0;
		div_a     = dvd_q;
		div_b     = dvs_q;
		mul_a     = quo_q;
		mul_b     = tc_q;
		case (state_q)
			ST_IDLE: if (start) state_d = ST_CHECK;
			ST_CHECK: begin
				if (dvs_q != '0) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else if (exists) begin
					// |t| mod n on the divider
					div_a     = tp_q[W-1] ? (W'(0) - tp_q) : tp_q;
					div_b     = {1'b0, n_q};
					div_start = 1'b1;
					state_d   = ST_RED;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				mul_a = div_quo;
				mul_b = sc_q;
				if (div_done) begin
					mul_start = 1'b1;
					state_d   = ST_MUL_S;
				end
			end
			ST_MUL_S: if (mul_done) begin
				mul_start = 1'b1;
				state_d   = ST_MUL_T;
			end
			ST_MUL_T: if (mul_done) state_d = ST_CHECK;
			ST_RED:   if (div_done) state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			dvd_q   <= '0;
			dvs_q   <= '0;
			quo_q   <= '0;
			sp_q    <= W'(1);
			sc_q    <= '0;
			tp_q    <= '0;
			tc_q    <= W'(1);
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				ST_IDLE: if (start) begin
					dvd_q <= {1'b0, operands.modulus};
					dvs_q <= {1'b0, operands.value};
					quo_q <= '0;
					sp_q  <= W'(1);
					sc_q  <= '0;
					tp_q  <= '0;
					tc_q  <= W'(1);
				end
				ST_DIV: if (div_done) begin
					quo_q <= div_quo;
					dvd_q <= dvs_q;
					dvs_q <= div_rem;
				end
				ST_MUL_S: if (mul_done) begin
					sp_q <= sc_q;
					sc_q <= sp_q - mul_p;
				end
				ST_MUL_T: if (mul_done) begin
					tp_q <= tc_q;
					tc_q <= tp_q - mul_p;
				end
				ST_DONE: done_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start)
			n_q <= operands.modulus;
		if (state_q == ST_CHECK && dvs_q == '0) begin
			res_q.divisor_common <= dvd_q[W-2:0];
			res_q.coeff_modulus  <= sp_q;
			res_q.coeff_value    <= tp_q;
			res_q.inverse        <= '0;
			res_q.inverse_exists <= exists;
		end
		if (state_q == ST_RED && div_done) begin
			// negative t: n - (|t| mod n), unless that remainder is zero
			if (res_q.coeff_value[W-1] && div_rem != '0)
				res_q.inverse <= n_q - div_rem[W-2:0];
			else
				res_q.inverse <= div_rem[W-2:0];
		end
	end

	meea_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_a),
		.divisor   (div_b),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	meea_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.done    (mul_done),
		.product (mul_p)
	);

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("transfer did not start a run");
	a_exists_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!result.inverse_exists || result.divisor_common == (W-1)'(1)))
		else $error("inverse flagged with gcd not one");
	a_units_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(div_start && mul_start)) else $error("both units launched");
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import meea_pkg::*;

	// Per run: up to ~92 Euclid steps, plus reduction.
	localparam int IDLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 400;

	logic clk;
	logic arst_n;
	logic start;
	in_t  operands;
	logic busy;
	logic done;
	out_t result;

	out_t inv_expected_q[$];
	bit   failed;
	int   idle_cycles;

	modular_inverse_ext_euclid DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.operands(operands),
		.busy(busy),
		.done(done),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Extended Euclid on (n, v), signed 64-bit coefficients.
	function automatic out_t euclid_inverse(logic [62:0] n, logic [62:0] v);
		logic [63:0] r0, r1, rt, q;
		logic [63:0] s0, s1, t0, t1, tmp, mag;
		out_t r;
		r0 = {1'b0, n};
		r1 = {1'b0, v};
		s0 = 64'd1;
		s1 = 64'd0;
		t0 = 64'd0;
		t1 = 64'd1;
		while (r1 != 64'd0) begin
			q = r0 / r1;
			rt = r0 % r1;
			r0 = r1;
			r1 = rt;
			tmp = s0 - q * s1;
			s0 = s1;
			s1 = tmp;
			tmp = t0 - q * t1;
			t0 = t1;
			t1 = tmp;
		end
		r.divisor_common = r0[62:0];
		r.coeff_modulus = s0;
		r.coeff_value = t0;
		r.inverse_exists = (r0 == 64'd1) && (n != 63'd0);
		r.inverse = '0;
		if (r.inverse_exists) begin
			if (t0[63]) begin
				mag = (64'd0 - t0) % {1'b0, n};
				tmp = (mag == 64'd0) ? 64'd0 : {1'b0, n} - mag;
			end else begin
				tmp = t0 % {1'b0, n};
			end
			r.inverse = tmp[62:0];
		end
		return r;
	endfunction

	// Sender: one transfer per call, inputs move on the falling edge.
	task automatic send_pair(logic [62:0] n, logic [62:0] v);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 3);
		repeat (gap) @(negedge clk);
		operands.modulus = n;
		operands.value = v;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		inv_expected_q.push_back(euclid_inverse(n, v));
		@(negedge clk);
		start <= 1'b0;
	endtask

	function automatic logic [62:0] rand63();
		return 63'({$urandom(), $urandom()});
	endfunction

	// Random width so small and huge operands both show up.
	function automatic logic [62:0] rand_sized();
		logic [62:0] x;
		int w;
		x = rand63();
		w = $urandom_range(1, 63);
		return x >> (63 - w);
	endfunction

	task automatic test_special_cases();
		send_pair(63'd0, 63'd0);
		send_pair(63'd17, 63'd0);
		send_pair(63'd0, 63'd23);
		send_pair(63'd1, 63'd5);
		send_pair(63'd12, 63'd8);
		send_pair(63'd7, 63'd3);
		send_pair(63'd3, 63'd7);
		send_pair(63'd26, 63'd26);
		send_pair('1, 63'd1);
		send_pair('1, '1);
		send_pair('1, 63'h7FFF_FFFF_FFFF_FFFE);
		send_pair(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA);
		// Consecutive Fibonacci numbers give the longest run.
		send_pair(63'd7540113804746346429, 63'd4660046610375530309);
		send_pair(63'd4660046610375530309, 63'd7540113804746346429);
		send_pair(63'h7FFF_FFFF_FFFF_FFE7, 63'd2);
	endtask

	task automatic test_drain_pause();
		while (inv_expected_q.size() != 0) @(posedge clk);
		send_pair(63'd1000000007, 63'd123456789);
	endtask

	task automatic test_random_pairs();
		logic [62:0] g;
		for (int i = 0; i < 90; i++) begin
			case ($urandom_range(0, 3))
				0: send_pair(rand63(), rand63());
				1: send_pair(rand_sized(), rand_sized());
				2: begin
					// Shared factor: no inverse.
					g = 63'($urandom_range(2, 1000));
					send_pair(g * ($urandom() + 1), g * $urandom_range(1, 1 << 20));
				end
				default: send_pair(rand_sized(), rand63());
			endcase
		end
	endtask

	// Checker: done is a one-cycle strobe, sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (inv_expected_q.size() == 0) begin
				$display("%t unexpected result %p", $time, result);
				failed = 1'b1;
			end else begin
				out_t e;
				e = inv_expected_q.pop_front();
				if (result.divisor_common !== e.divisor_common) begin
					$display("%t gcd exp %h act %h", $time, e.divisor_common,
						result.divisor_common);
					failed = 1'b1;
				end
				if (result.coeff_modulus !== e.coeff_modulus) begin
					$display("%t s exp %h act %h", $time, e.coeff_modulus,
						result.coeff_modulus);
					failed = 1'b1;
				end
				if (result.coeff_value !== e.coeff_value) begin
					$display("%t t exp %h act %h", $time, e.coeff_value, result.coeff_value);
					failed = 1'b1;
				end
				if (result.inverse !== e.inverse) begin
					$display("%t inverse exp %h act %h", $time, e.inverse, result.inverse);
					failed = 1'b1;
				end
				if (result.inverse_exists !== e.inverse_exists) begin
					$display("%t exists exp %b act %b", $time, e.inverse_exists,
						result.inverse_exists);
					failed = 1'b1;
				end
			end
		end
	end

	// Watchdog: counts cycles with no transfer either way.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		failed = 1'b0;
		idle_cycles = 0;
		start = 1'b0;
		operands = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_special_cases();
		test_drain_pause();
		test_random_pairs();
		while (inv_expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed && inv_expected_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire

// ----- filelist.f -----
hw/rtl/meea_pkg.sv
hw/rtl/meea_div.sv
hw/rtl/meea_mul.sv
hw/rtl/modular_inverse_ext_euclid.sv
tb/tb_top.sv
